>>> hw/rtl/cgl_pkg.sv
package cgl_pkg;

  // Fixed field widths of the sample, the fraction and the colors.
  localparam int SAMPLE_W   = 16;
  localparam int FRAC_W     = 17;
  localparam int STOP_W     = 24;
  localparam int CH_W       = 8;
  localparam int COARSE_W   = 3;
  localparam int PAIR_W     = 48;
  localparam int PAIRS      = 4;
  localparam int STOPS_ALL  = 8;
  localparam int STOP_IDX_W = 3;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;
  localparam int MIX_W      = 24;

  localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'h10000;
  localparam logic [CH_W-1:0]   CH_THRESH = 8'd127;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_STOPS_A    = 4'd0;
  localparam cfg_idx_t REG_STOPS_B    = 4'd1;
  localparam cfg_idx_t REG_STOPS_C    = 4'd2;
  localparam cfg_idx_t REG_STOPS_D    = 4'd3;
  localparam cfg_idx_t REG_STOP_COUNT = 4'd4;
  localparam cfg_idx_t REG_MODE       = 4'd5;
  localparam cfg_idx_t REG_LOW_BOUND  = 4'd6;
  localparam cfg_idx_t REG_HIGH_BOUND = 4'd7;

  localparam logic [PAIR_W-1:0]   STOPS_A_RST    = 48'hFFFFFF000000;
  localparam logic [COUNT_W-1:0]  STOP_COUNT_RST = 4'd2;
  localparam logic [SAMPLE_W-1:0] HIGH_BOUND_RST = 16'hFFFF;

  // How the fraction of a sample is formed before invert and square root.
  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_ONE  = 2'd1,
    CLS_DIV  = 2'd2
  } frac_cls_t;

  typedef struct packed {
    logic sqrt_en;
    logic invert;
  } mode_t;

endpackage

>>> hw/rtl/cgl_div.sv
// Pipelined restoring divider for a numerator known to be below the divisor.
// The quotient is the fraction numerator * 2^W / divisor.
module cgl_div #(
  parameter int W              = 16,
  parameter int BITS_PER_STAGE = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [W-1:0]        in_num,
  input  logic [W-1:0]        in_den,
  input  cgl_pkg::frac_cls_t  in_cls,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [W-1:0]        out_quo,
  output cgl_pkg::frac_cls_t  out_cls
);

  localparam int STAGES = (W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

  logic [STAGES-1:0]  vld_r;
  logic [STAGES:0]    en;
  logic [W-1:0]       rem_r [STAGES];
  logic [W-1:0]       quo_r [STAGES];
  logic [W-1:0]       den_r [STAGES];
  cgl_pkg::frac_cls_t cls_r [STAGES];

  assign en[STAGES] = out_ready;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic               vld_in;
    logic [W-1:0]       rem_in;
    logic [W-1:0]       quo_in;
    logic [W-1:0]       den_in;
    cgl_pkg::frac_cls_t cls_in;
    logic [W-1:0]       rem_nxt;
    logic [W-1:0]       quo_nxt;

    if (s == 0) begin : g_first
      assign vld_in = in_valid;
      assign rem_in = in_num;
      assign quo_in = '0;
      assign den_in = in_den;
      assign cls_in = in_cls;
    end else begin : g_next
      assign vld_in = vld_r[s-1];
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
      assign den_in = den_r[s-1];
      assign cls_in = cls_r[s-1];
    end

    assign en[s] = !vld_r[s] || en[s+1];

    always_comb begin
      logic [W:0]   r2;
      logic [W-1:0] rv;
      logic [W-1:0] qv;
      rv = rem_in;
      qv = quo_in;
      r2 = '0;
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        if (s * BITS_PER_STAGE + j < W) begin
          r2 = {rv, 1'b0};
          if (r2 >= {1'b0, den_in}) begin
            r2 = r2 - {1'b0, den_in};
            qv = {qv[W-2:0], 1'b1};
          end else begin
            qv = {qv[W-2:0], 1'b0};
          end
          rv = r2[W-1:0];
        end
      end
      rem_nxt = rv;
      quo_nxt = qv;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en[s]) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s] <= rem_nxt;
        quo_r[s] <= quo_nxt;
        den_r[s] <= den_in;
        cls_r[s] <= cls_in;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[STAGES-1];
  assign out_quo   = quo_r[STAGES-1];
  assign out_cls   = cls_r[STAGES-1];

endmodule

>>> hw/rtl/cgl_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per step.
// A side word travels along with each radicand.
module cgl_sqrt #(
  parameter int RW             = 17,
  parameter int SW             = 17,
  parameter int BITS_PER_STAGE = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2*RW-1:0] in_rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [RW-1:0]   out_root,
  output logic [SW-1:0]   out_side
);

  localparam int STAGES = (RW + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int RMW    = RW + 4;

  logic [STAGES-1:0] vld_r;
  logic [STAGES:0]   en;
  logic [2*RW-1:0]   rad_r  [STAGES];
  logic [RMW-1:0]    rem_r  [STAGES];
  logic [RW-1:0]     root_r [STAGES];
  logic [SW-1:0]     side_r [STAGES];

  assign en[STAGES] = out_ready;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic            vld_in;
    logic [2*RW-1:0] rad_in;
    logic [RMW-1:0]  rem_in;
    logic [RW-1:0]   root_in;
    logic [SW-1:0]   side_in;
    logic [2*RW-1:0] rad_nxt;
    logic [RMW-1:0]  rem_nxt;
    logic [RW-1:0]   root_nxt;

    if (s == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rad_in  = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign rad_in  = rad_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign side_in = side_r[s-1];
    end

    assign en[s] = !vld_r[s] || en[s+1];

    always_comb begin
      logic [2*RW-1:0] xv;
      logic [RMW-1:0]  rv;
      logic [RMW-1:0]  trial;
      logic [RW-1:0]   qv;
      xv    = rad_in;
      rv    = rem_in;
      qv    = root_in;
      trial = '0;
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        if (s * BITS_PER_STAGE + j < RW) begin
          // Bring down the next two radicand bits and try 4q + 1.
          rv    = {rv[RMW-3:0], xv[2*RW-1 -: 2]};
          xv    = {xv[2*RW-3:0], 2'b00};
          trial = {2'b00, qv, 2'b01};
          if (rv >= trial) begin
            rv = rv - trial;
            qv = {qv[RW-2:0], 1'b1};
          end else begin
            qv = {qv[RW-2:0], 1'b0};
          end
        end
      end
      rad_nxt  = xv;
      rem_nxt  = rv;
      root_nxt = qv;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en[s]) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rad_r[s]  <= rad_nxt;
        rem_r[s]  <= rem_nxt;
        root_r[s] <= root_nxt;
        side_r[s] <= side_in;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[STAGES-1];
  assign out_root  = root_r[STAGES-1];
  assign out_side  = side_r[STAGES-1];

endmodule

>>> hw/rtl/color_gradient_lookup_top.sv
// Multi-stop color gradient lookup. Each input beat carries one sample value,
// and each output beat carries the red, green and blue of that sample on a
// gradient of up to eight color stops, plus a 3-bit coarse color (one bit per
// channel above 127). The block takes one sample per clock and delivers one
// color per clock while the output is taken. The pipeline is made of the
// fraction divider, which retires two quotient bits per stage over 8 stages,
// and the square root unit, which retires up to two root bits per stage over
// 9 stages, plus five stages of framing, scaling and blending. Every stage
// holds its own valid bit and fills when it is empty or the one ahead of it
// moves, so bubbles close up and a stalled output does not stop intake until
// the pipeline is really full. Configuration is written through a plain
// write port and must only change while no beat is in flight.
module color_gradient_lookup_top #(
  parameter int MAX_STOPS  = 8,
  parameter int VALUE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [cgl_pkg::SAMPLE_W-1:0]     in_sample_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [cgl_pkg::CH_W-1:0]         out_red,
  output logic [cgl_pkg::CH_W-1:0]         out_green,
  output logic [cgl_pkg::CH_W-1:0]         out_blue,
  output logic [cgl_pkg::COARSE_W-1:0]     out_coarse_color,
  input  logic                             cfg_we,
  input  logic [cgl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cgl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int SW    = cgl_pkg::SAMPLE_W;
  localparam int FW    = cgl_pkg::FRAC_W;
  localparam int CW    = cgl_pkg::CH_W;
  localparam int NM1_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int VB    = (VALUE_BITS < SW) ? VALUE_BITS : SW;
  localparam logic [SW-1:0] VALUE_MASK = SW'(({(SW+1){1'b0}} | 1) << VB) - SW'(1);
  localparam logic [cgl_pkg::COUNT_W-1:0] MAX_COUNT = cgl_pkg::COUNT_W'(MAX_STOPS);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [cgl_pkg::PAIR_W-1:0]  pairs_r [cgl_pkg::PAIRS];
  logic [cgl_pkg::COUNT_W-1:0] stop_count_r;
  cgl_pkg::mode_t              mode_r;
  logic [SW-1:0]               low_bound_r;
  logic [SW-1:0]               high_bound_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pairs_r[0]   <= cgl_pkg::STOPS_A_RST;
      pairs_r[1]   <= '0;
      pairs_r[2]   <= '0;
      pairs_r[3]   <= '0;
      stop_count_r <= cgl_pkg::STOP_COUNT_RST;
      mode_r       <= '0;
      low_bound_r  <= '0;
      high_bound_r <= cgl_pkg::HIGH_BOUND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cgl_pkg::REG_STOPS_A:    pairs_r[0]   <= cfg_wdata;
        cgl_pkg::REG_STOPS_B:    pairs_r[1]   <= cfg_wdata;
        cgl_pkg::REG_STOPS_C:    pairs_r[2]   <= cfg_wdata;
        cgl_pkg::REG_STOPS_D:    pairs_r[3]   <= cfg_wdata;
        cgl_pkg::REG_STOP_COUNT: stop_count_r <= cfg_wdata[cgl_pkg::COUNT_W-1:0];
        cgl_pkg::REG_MODE:       mode_r       <= cgl_pkg::mode_t'(cfg_wdata[1:0]);
        cgl_pkg::REG_LOW_BOUND:  low_bound_r  <= cfg_wdata[SW-1:0];
        cgl_pkg::REG_HIGH_BOUND: high_bound_r <= cfg_wdata[SW-1:0];
        default: ;
      endcase
    end
  end

  // Individual stops: red in the top byte, blue in the bottom byte.
  logic [cgl_pkg::STOP_W-1:0] stop_rgb [cgl_pkg::STOPS_ALL];

  for (genvar k = 0; k < cgl_pkg::STOPS_ALL; k++) begin : g_stop
    assign stop_rgb[k] = pairs_r[k/2][(k%2)*cgl_pkg::STOP_W +: cgl_pkg::STOP_W];
  end

  // Stop count in use, clamped to the supported range, less one.
  logic [cgl_pkg::COUNT_W-1:0] n_eff;
  logic [NM1_W-1:0]            nm1;

  always_comb begin
    if (stop_count_r < cgl_pkg::COUNT_W'(2)) begin
      n_eff = cgl_pkg::COUNT_W'(2);
    end else if (stop_count_r > MAX_COUNT) begin
      n_eff = MAX_COUNT;
    end else begin
      n_eff = stop_count_r;
    end
  end

  assign nm1 = NM1_W'(n_eff - cgl_pkg::COUNT_W'(1));

  // ---------------------------------------------------------------------
  // Stage T0: classify the sample against the bounds.
  // ---------------------------------------------------------------------
  logic               v0_r;
  logic               en0;
  logic [SW-1:0]      num0_r;
  logic [SW-1:0]      den0_r;
  cgl_pkg::frac_cls_t cls0_r;
  logic [SW-1:0]      sample_m;
  cgl_pkg::frac_cls_t cls0_nxt;
  logic               div_in_ready;

  assign sample_m = in_sample_value & VALUE_MASK;

  always_comb begin
    if (high_bound_r <= low_bound_r || sample_m <= low_bound_r) begin
      cls0_nxt = cgl_pkg::CLS_ZERO;
    end else if (sample_m >= high_bound_r) begin
      cls0_nxt = cgl_pkg::CLS_ONE;
    end else begin
      cls0_nxt = cgl_pkg::CLS_DIV;
    end
  end

  assign en0      = !v0_r || div_in_ready;
  assign in_ready = en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en0) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      num0_r <= sample_m - low_bound_r;
      den0_r <= high_bound_r - low_bound_r;
      cls0_r <= cls0_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Fraction divider: (sample - low) * 2^16 / (high - low).
  // ---------------------------------------------------------------------
  logic               div_valid;
  logic [SW-1:0]      div_quo;
  cgl_pkg::frac_cls_t div_cls;
  logic               en1;

  cgl_div #(
    .W              (SW),
    .BITS_PER_STAGE (2)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v0_r),
    .in_ready  (div_in_ready),
    .in_num    (num0_r),
    .in_den    (den0_r),
    .in_cls    (cls0_r),
    .out_valid (div_valid),
    .out_ready (en1),
    .out_quo   (div_quo),
    .out_cls   (div_cls)
  );

  // ---------------------------------------------------------------------
  // Stage T1: pick the fraction for the clamped cases and invert it in invert mode.
  // ---------------------------------------------------------------------
  logic          v1_r;
  logic [FW-1:0] f1_r;
  logic [FW-1:0] f_raw;
  logic [FW-1:0] f1_nxt;
  logic          sq_in_ready;

  always_comb begin
    case (div_cls)
      cgl_pkg::CLS_ZERO: f_raw = '0;
      cgl_pkg::CLS_ONE:  f_raw = cgl_pkg::FRAC_ONE;
      cgl_pkg::CLS_DIV:  f_raw = {1'b0, div_quo};
      default:           f_raw = '0;
    endcase
    f1_nxt = mode_r.invert ? (cgl_pkg::FRAC_ONE - f_raw) : f_raw;
  end

  assign en1 = !v1_r || sq_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      f1_r <= f1_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Square root of the fraction, taken as sqrt(f * 2^16). The plain
  // fraction rides along so the root can be bypassed at the far end.
  // ---------------------------------------------------------------------
  logic          sq_valid;
  logic [FW-1:0] sq_root;
  logic [FW-1:0] sq_side;
  logic          en2;

  cgl_sqrt #(
    .RW             (FW),
    .SW             (FW),
    .BITS_PER_STAGE (2)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1_r),
    .in_ready  (sq_in_ready),
    .in_rad    ({1'b0, f1_r, {SW{1'b0}}}),
    .in_side   (f1_r),
    .out_valid (sq_valid),
    .out_ready (en2),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // ---------------------------------------------------------------------
  // Stage T2: scale by (stops - 1) into a segment and a remainder. At the
  // very end of the gradient the last segment is kept with a full weight.
  // ---------------------------------------------------------------------
  logic                v2_r;
  logic [NM1_W-1:0]    seg2_r;
  logic [FW-1:0]       rem2_r;
  logic [FW-1:0]       f2;
  logic [FW+NM1_W-1:0] t2;
  logic [NM1_W-1:0]    seg_raw;
  logic [NM1_W-1:0]    seg2_nxt;
  logic [FW-1:0]       rem2_nxt;
  logic                en3;

  assign f2      = mode_r.sqrt_en ? sq_root : sq_side;
  assign t2      = (FW+NM1_W)'(f2) * (FW+NM1_W)'(nm1);
  assign seg_raw = t2[SW +: NM1_W];

  always_comb begin
    if (seg_raw >= nm1) begin
      seg2_nxt = nm1 - NM1_W'(1);
      rem2_nxt = cgl_pkg::FRAC_ONE;
    end else begin
      seg2_nxt = seg_raw;
      rem2_nxt = {1'b0, t2[SW-1:0]};
    end
  end

  assign en2 = !v2_r || en3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      seg2_r <= seg2_nxt;
      rem2_r <= rem2_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage T3: fetch the two neighboring stops and form the weighted
  // products of each channel.
  // ---------------------------------------------------------------------
  logic                            v3_r;
  logic [cgl_pkg::MIX_W-1:0]       mix_a_r [3];
  logic [cgl_pkg::MIX_W-1:0]       mix_b_r [3];
  logic [cgl_pkg::MIX_W-1:0]       mix_a_nxt [3];
  logic [cgl_pkg::MIX_W-1:0]       mix_b_nxt [3];
  logic [cgl_pkg::STOP_IDX_W-1:0]  idx_a;
  logic [cgl_pkg::STOP_IDX_W-1:0]  idx_b;
  logic [cgl_pkg::STOP_W-1:0]      stop_a;
  logic [cgl_pkg::STOP_W-1:0]      stop_b;
  logic [FW-1:0]                   w_a;
  logic                            en4;

  assign idx_a  = cgl_pkg::STOP_IDX_W'(seg2_r);
  assign idx_b  = idx_a + cgl_pkg::STOP_IDX_W'(1);
  assign stop_a = stop_rgb[idx_a];
  assign stop_b = stop_rgb[idx_b];
  assign w_a    = cgl_pkg::FRAC_ONE - rem2_r;

  always_comb begin
    logic [FW+CW-1:0] pa;
    logic [FW+CW-1:0] pb;
    for (int c = 0; c < 3; c++) begin
      // Channel 0 is red in the top byte of a stop.
      pa = (FW+CW)'(stop_a[CW*(2-c) +: CW]) * (FW+CW)'(w_a);
      pb = (FW+CW)'(stop_b[CW*(2-c) +: CW]) * (FW+CW)'(rem2_r);
      mix_a_nxt[c] = pa[cgl_pkg::MIX_W-1:0];
      mix_b_nxt[c] = pb[cgl_pkg::MIX_W-1:0];
    end
  end

  assign en3 = !v3_r || en4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int c = 0; c < 3; c++) begin
        mix_a_r[c] <= mix_a_nxt[c];
        mix_b_r[c] <= mix_b_nxt[c];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage T4: output register. The blend sum is truncated to the channel
  // and each channel is tested against the coarse threshold.
  // ---------------------------------------------------------------------
  logic                        v4_r;
  logic [CW-1:0]               ch4_r [3];
  logic [CW-1:0]               ch4_nxt [3];

  always_comb begin
    logic [cgl_pkg::MIX_W:0] sum;
    for (int c = 0; c < 3; c++) begin
      sum        = {1'b0, mix_a_r[c]} + {1'b0, mix_b_r[c]};
      ch4_nxt[c] = sum[SW +: CW];
    end
  end

  assign en4 = !v4_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int c = 0; c < 3; c++) begin
        ch4_r[c] <= ch4_nxt[c];
      end
    end
  end

  assign out_valid        = v4_r;
  assign out_red          = ch4_r[0];
  assign out_green        = ch4_r[1];
  assign out_blue         = ch4_r[2];
  assign out_coarse_color = {ch4_r[2] > cgl_pkg::CH_THRESH,
                             ch4_r[1] > cgl_pkg::CH_THRESH,
                             ch4_r[0] > cgl_pkg::CH_THRESH};

endmodule

>>> hw/rtl/cgl_checker.sv
// Port-level checks for the gradient lookup.
module cgl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cgl_pkg::CH_W-1:0]      out_red,
  input logic [cgl_pkg::CH_W-1:0]      out_green,
  input logic [cgl_pkg::CH_W-1:0]      out_blue,
  input logic [cgl_pkg::COARSE_W-1:0]  out_coarse_color
);

  // The coarse color must agree with the channels it is derived from.
  a_coarse_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_coarse_color[0] == (out_red   > cgl_pkg::CH_THRESH)) &&
                  (out_coarse_color[1] == (out_green > cgl_pkg::CH_THRESH)) &&
                  (out_coarse_color[2] == (out_blue  > cgl_pkg::CH_THRESH)))
    else $error("coarse color does not match channels");

  // With the sink taking every beat, no stage can be blocked.
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is ready");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // A result that is not taken holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) &&
                                $stable(out_green) && $stable(out_blue))
    else $error("stalled result changed");

endmodule

bind color_gradient_lookup_top cgl_checker u_cgl_checker (.*);
